### hdl/sms_pkg.sv
// Shared types and constants of the sorted multiset store.
// Used by the channel interfaces, the cell and the top level.
package sms_pkg;

   localparam int CAPACITY_DEF = 256;
   localparam int MATCH_W      = 9;
   localparam int MATCH_MAX    = 511;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_SEARCH = 2'd2,
      OP_RANGE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_FULL   = 2'd1,
      ST_ABSENT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CMP  = 3'b010,
      S_RES  = 3'b100
   } fsm_type;

   // Broadcast from the sequencer to every cell of the chain.
   typedef struct packed {
      logic               load;
      logic               ins;
      logic               del;
      logic signed [31:0] key;
      logic signed [31:0] key_high;
   } cell_ctrl_type;

   // Comparison results that each cell holds for the current request.
   typedef struct packed {
      logic le_k;
      logic lt_k;
      logic le_kh;
   } cell_flags_type;

endpackage

### hdl/sms_req_if.sv
// Request channel of the sorted multiset store.
// Depends on sms_pkg for the request code type.
interface sms_req_if;
   logic               valid;
   logic               ready;
   sms_pkg::op_type    req_type;
   logic signed [31:0] key;
   logic signed [31:0] key_high;

   modport source (output valid, output req_type, output key, output key_high, input ready);
   modport sink   (input valid, input req_type, input key, input key_high, output ready);
endinterface

### hdl/sms_rsp_if.sv
// Response channel of the sorted multiset store.
// Depends on sms_pkg for the status type and count width.
interface sms_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [sms_pkg::MATCH_W-1:0]      match_count;
   sms_pkg::status_type              status;

   modport source (output valid, output hit, output match_count, output status, input ready);
   modport sink   (input valid, input hit, input match_count, input status, output ready);
endinterface

### hdl/sms_cell.sv
// One cell of the sorted key chain: holds one key and its comparison flags.
// Depends on sms_pkg for the control and flag structs.
module sms_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  sms_pkg::cell_ctrl_type  ctrl,
   input  logic                    occ,
   input  logic signed [31:0]      left_key,
   input  logic                    left_le,
   input  logic signed [31:0]      right_key,
   output logic signed [31:0]      key_out,
   output sms_pkg::cell_flags_type flags_out
);
   import sms_pkg::*;

   logic signed [31:0] key_ff, key_in;
   cell_flags_type     flags_ff, flags_in;

   always_comb begin
      flags_in.le_k  = occ && (key_ff <= ctrl.key);
      flags_in.lt_k  = occ && (key_ff <  ctrl.key);
      flags_in.le_kh = occ && (key_ff <= ctrl.key_high);
   end

   // Insert moves every key above the slot one cell right; erase moves every
   // key from the removed one onward one cell left.
   always_comb begin
      key_in = key_ff;
      if (ctrl.ins) begin
         if (!flags_ff.le_k) begin
            key_in = left_le ? ctrl.key : left_key;
         end
      end else if (ctrl.del) begin
         if (!flags_ff.lt_k) begin
            key_in = right_key;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (ctrl.load) begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out   = key_ff;
   assign flags_out = flags_ff;
endmodule

### hdl/sms_therm_enc.sv
// Counts the ones of a thermometer code by locating its single falling edge.
// Standalone; used by the top level for position lookups.
module sms_therm_enc #(
   parameter int N = 256,
   parameter int W = $clog2(N + 1)
) (
   input  logic [N-1:0] therm,
   output logic [W-1:0] ones
);
   always_comb begin
      ones = '0;
      for (int i = 0; i < N; i++) begin
         if (therm[i] && (i == N - 1 || !therm[(i + 1) % N])) begin
            ones = ones | W'(i + 1);
         end
      end
   end
endmodule

### hdl/sorted_multiset_store.sv
// Sorted multiset store: a chain of key cells kept in ascending signed order.
// Each request is accepted, compared in all cells, then resolved and shifted; the response is registered at resolve.
// A new request is taken only after the previous one has been resolved.
// A waiting response does not block the next request transfer; resolve waits for the slot.
// Reset clears the live count and control state; key cells are not cleared.
module sorted_multiset_store #(
   parameter int CAPACITY = sms_pkg::CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sms_req_if.sink    req_chan,
   sms_rsp_if.source  rsp_chan
);
   import sms_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = (CNT_W > MATCH_W) ? CNT_W : MATCH_W;

   fsm_type            state_ff, state_in;
   op_type             op_ff;
   logic signed [31:0] key_ff, kh_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               hit_ff, hit_in;
   logic [MATCH_W-1:0] match_ff, match_in;
   status_type         status_ff, status_in;

   cell_ctrl_type      ctrl;
   logic signed [31:0] cell_key [CAPACITY];
   cell_flags_type     cell_flags [CAPACITY];
   logic [CAPACITY-1:0] le_vec, lt_vec, lekh_vec, occ_vec, left_le_vec;
   logic [CNT_W-1:0]   n_le, n_lt, n_lekh;

   logic slot_free, full, found, resolve;
   logic [SUM_W-1:0] span;

   // The chain of cells. Each cell sees its left neighbor's key and flag for
   // insert and its right neighbor's key for erase.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ_vec[i]  = (CNT_W'(i) < count_ff);
      assign le_vec[i]   = cell_flags[i].le_k;
      assign lt_vec[i]   = cell_flags[i].lt_k;
      assign lekh_vec[i] = cell_flags[i].le_kh;
      if (i == 0) begin : g_first
         assign left_le_vec[i] = 1'b1;
      end else begin : g_rest
         assign left_le_vec[i] = le_vec[i-1];
      end
      sms_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .occ       (occ_vec[i]),
         .left_key  ((i == 0) ? key_ff : cell_key[(i + CAPACITY - 1) % CAPACITY]),
         .left_le   (left_le_vec[i]),
         .right_key ((i == CAPACITY - 1) ? cell_key[i] : cell_key[(i + 1) % CAPACITY]),
         .key_out   (cell_key[i]),
         .flags_out (cell_flags[i])
      );
   end

   // Flags form thermometer codes because keys are sorted, so each count is
   // the position of the code's falling edge.
   sms_therm_enc #(.N(CAPACITY), .W(CNT_W)) u_enc_le   (.therm(le_vec),   .ones(n_le));
   sms_therm_enc #(.N(CAPACITY), .W(CNT_W)) u_enc_lt   (.therm(lt_vec),   .ones(n_lt));
   sms_therm_enc #(.N(CAPACITY), .W(CNT_W)) u_enc_lekh (.therm(lekh_vec), .ones(n_lekh));

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign resolve   = (state_ff == S_RES) && slot_free;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   // The key is present exactly when some stored key is equal to it.
   assign found     = (n_le > n_lt);

   always_comb begin
      ctrl.load     = (state_ff == S_CMP);
      ctrl.ins      = resolve && (op_ff == OP_INSERT) && !full;
      ctrl.del      = resolve && (op_ff == OP_ERASE) && found;
      ctrl.key      = key_ff;
      ctrl.key_high = kh_ff;
   end

   always_comb begin
      span = (key_ff <= kh_ff) ? SUM_W'(n_lekh - n_lt) : '0;
      hit_in    = 1'b0;
      match_in  = '0;
      status_in = ST_DONE;
      unique case (op_ff)
         OP_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end
         end
         OP_ERASE: begin
            hit_in = found;
            if (!found) begin
               status_in = ST_ABSENT;
            end
         end
         OP_SEARCH: begin
            hit_in = found;
         end
         OP_RANGE: begin
            match_in = (span > SUM_W'(MATCH_MAX)) ? MATCH_W'(MATCH_MAX) : span[MATCH_W-1:0];
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.del) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_RES;
         end
         S_RES: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (resolve) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         op_ff  <= req_chan.req_type;
         key_ff <= req_chan.key;
         kh_ff  <= req_chan.key_high;
      end
      if (resolve) begin
         hit_ff    <= hit_in;
         match_ff  <= match_in;
         status_ff <= status_in;
      end
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = hit_ff;
   assign rsp_chan.match_count = match_ff;
   assign rsp_chan.status      = status_ff;
endmodule
